### hw/rtl/keypad_press_hold_wheel_decoder_assert.svh
// Assertion macros shared by the keypad decoder RTL.
`ifndef KEYPAD_PRESS_HOLD_WHEEL_DECODER_ASSERT_SVH
`define KEYPAD_PRESS_HOLD_WHEEL_DECODER_ASSERT_SVH

// Same-cycle implication, checked on clk_i with reset asserted low.
`define KPHW_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("keypad decoder: implication check failed");

// Next-cycle implication, checked on clk_i with reset asserted low.
`define KPHW_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("keypad decoder: next-cycle check failed");

`endif

### hw/rtl/kphw_pkg.sv
// Shared types and constants of the keypad press/hold and wheel decoder.
package kphw_pkg;

  localparam int unsigned CounterBitsDef = 16;
  localparam int unsigned KeyBitsW = 9;
  localparam int unsigned PressW = 13;
  localparam int unsigned HoldW = 15;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 15;
  localparam int unsigned NumButtons = 6;
  localparam int unsigned WheelLo = 3;
  localparam int unsigned CntCap = 32'h7fff;
  localparam int unsigned HoldReloadMul = 7;

  localparam int unsigned BtnContact [NumButtons] = '{0, 1, 2, 6, 7, 8};

  localparam logic [PressW-1:0] PressIntervalRst = 13'd10;
  localparam logic [HoldW-1:0] HoldIntervalRst = 15'd100;

  typedef enum logic [CfgIdxW-1:0] {
    RegPressInterval = 2'd0,
    RegHoldInterval  = 2'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    EvNone    = 2'd0,
    EvPressed = 2'd1,
    EvHold    = 2'd2
  } key_event_e;

  typedef enum logic [1:0] {
    WhNone = 2'd0,
    WhDown = 2'd1,
    WhUp   = 2'd2
  } wheel_event_e;

  typedef enum logic [1:0] {
    Pos0       = 2'd0,
    Pos1       = 2'd1,
    Pos2       = 2'd2,
    PosUnknown = 2'd3
  } wheel_pos_e;

  typedef struct packed {
    logic [PressW-1:0] press_interval;
    logic [HoldW-1:0]  hold_interval;
  } cfg_t;

endpackage

### hw/rtl/kphw_button.sv
// One button contact: saturating hold counter with press and hold detection.
module kphw_button #(
  parameter int unsigned CounterBits = kphw_pkg::CounterBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          closed_i,
  input  kphw_pkg::cfg_t                cfg_i,
  input  logic signed [CounterBits-1:0] reload_i,
  output kphw_pkg::key_event_e          event_o
);
  import kphw_pkg::*;

  localparam int unsigned CmpW = (CounterBits > HoldW ? CounterBits : HoldW) + 1;
  localparam logic signed [CounterBits-1:0] CntMax = CounterBits'(
    (CounterBits > 16) ? 64'(CntCap) : ((64'd1 << (CounterBits - 1)) - 64'd1));

  logic signed [CounterBits-1:0] count_q, count_d, count_inc;
  logic signed [CmpW-1:0]        count_x, press_x, hold_x;

  assign count_inc = (closed_i && (count_q < CntMax)) ? count_q + 1'b1 : count_q;
  assign count_x = CmpW'(count_inc);
  assign press_x = $signed({{(CmpW-PressW){1'b0}}, cfg_i.press_interval});
  assign hold_x = $signed({{(CmpW-HoldW){1'b0}}, cfg_i.hold_interval});

  always_comb begin
    event_o = EvNone;
    count_d = count_inc;
    if (!closed_i && (count_x > press_x) && (count_x < hold_x)) begin
      event_o = EvPressed;
      count_d = '0;
    end else if (count_x == hold_x) begin
      event_o = EvHold;
      count_d = reload_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (adv_i) begin
      count_q <= count_d;
    end
  end

endmodule

### hw/rtl/kphw_wheel.sv
// Three-phase wheel: phase counters, position tracking and turn direction.
module kphw_wheel #(
  parameter int unsigned CounterBits = kphw_pkg::CounterBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   adv_i,
  input  logic [2:0]             phase_i,
  output kphw_pkg::wheel_event_e event_o
);
  import kphw_pkg::*;

  localparam logic signed [CounterBits-1:0] CntMax = CounterBits'(
    (CounterBits > 16) ? 64'(CntCap) : ((64'd1 << (CounterBits - 1)) - 64'd1));

  logic signed [CounterBits-1:0] cnt_q [3];
  logic signed [CounterBits-1:0] cnt_inc [3];
  logic signed [CounterBits-1:0] cnt_d [3];
  wheel_pos_e                    pos_q, pos_d, pos_new;
  logic                          any_nz;
  logic                          down;

  for (genvar p = 0; p < 3; p++) begin : g_phase
    assign cnt_inc[p] = (phase_i[p] && (cnt_q[p] < CntMax)) ? cnt_q[p] + 1'b1 : cnt_q[p];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cnt_q[p] <= '0;
      end else if (adv_i) begin
        cnt_q[p] <= cnt_d[p];
      end
    end
  end

  assign any_nz = (cnt_inc[0] != '0) || (cnt_inc[1] != '0) || (cnt_inc[2] != '0);

  always_comb begin
    cnt_d = cnt_inc;
    if (cnt_inc[0] > 0) begin
      pos_new = Pos0;
    end else if (cnt_inc[1] > 0) begin
      pos_new = Pos1;
    end else begin
      pos_new = Pos2;
    end
    if (any_nz) begin
      case (pos_new)
        Pos0:    cnt_d[0] = '0;
        Pos1:    cnt_d[1] = '0;
        default: cnt_d[2] = '0;
      endcase
    end
  end

  always_comb begin
    case (pos_q)
      Pos0:    down = (pos_new == Pos1);
      Pos1:    down = (pos_new == Pos2);
      Pos2:    down = (pos_new == Pos0);
      default: down = 1'b0;
    endcase
  end

  always_comb begin
    event_o = WhNone;
    pos_d = pos_q;
    if (any_nz) begin
      pos_d = pos_new;
      if ((pos_q != PosUnknown) && (pos_new != pos_q)) begin
        event_o = down ? WhDown : WhUp;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= PosUnknown;
    end else if (adv_i) begin
      pos_q <= pos_d;
    end
  end

  `include "keypad_press_hold_wheel_decoder_assert.svh"

  `KPHW_ASSERT_NXT(a_pos_stays_known, pos_q != PosUnknown, pos_q != PosUnknown)
  `KPHW_ASSERT_IMP(a_turn_needs_known, adv_i && (event_o != WhNone), pos_q != PosUnknown)
  `KPHW_ASSERT_NXT(a_turn_moves_pos, adv_i && (event_o != WhNone), pos_q != $past(pos_q))

endmodule

### hw/rtl/keypad_press_hold_wheel_decoder.sv
// Keypad press/hold decoder with rotary wheel: top level.
// Accepted scans enter the input register; decoded events load the result register on advance.
// Throughput: one scan per cycle; the input register advances whenever the
// result register is empty or being taken, so stall only holds with both full.
// Reset: counters clear, wheel position goes unknown, intervals return to 10 and
// 100; no clearing pass, a scan can be accepted as soon as reset is released.
module keypad_press_hold_wheel_decoder #(
  parameter int unsigned CounterBits = kphw_pkg::CounterBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [kphw_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [kphw_pkg::CfgDataW-1:0]     cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [kphw_pkg::KeyBitsW-1:0]     key_bits_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [1:0]                        key0_event_o,
  output logic [1:0]                        key1_event_o,
  output logic [1:0]                        key2_event_o,
  output logic [1:0]                        key6_event_o,
  output logic [1:0]                        key7_event_o,
  output logic [1:0]                        key8_event_o,
  output logic [1:0]                        wheel_event_o
);
  import kphw_pkg::*;

  localparam int unsigned RelW = (CounterBits > 18) ? CounterBits + 1 : 19;

  cfg_t                  cfg_q;
  logic                  s1_valid_q;
  logic [KeyBitsW-1:0]   key_bits_q;
  logic                  out_valid_q;
  logic                  advance;
  logic [15:0]           reload_mag;
  logic signed [RelW-1:0] reload_full, cnt_min_x;
  logic signed [CounterBits-1:0] reload;
  key_event_e            key_ev [NumButtons];
  key_event_e            key_ev_q [NumButtons];
  wheel_event_e          wheel_ev, wheel_ev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.press_interval <= PressIntervalRst;
      cfg_q.hold_interval <= HoldIntervalRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegPressInterval: cfg_q.press_interval <= cfg_wdata_i[PressW-1:0];
        RegHoldInterval:  cfg_q.hold_interval <= cfg_wdata_i[HoldW-1:0];
        default:          ;
      endcase
    end
  end

  // hold reload = -7 * press_interval, saturated to the counter minimum
  assign reload_mag = 16'(cfg_q.press_interval) * 16'(HoldReloadMul);
  assign reload_full = -$signed({{(RelW-16){1'b0}}, reload_mag});
  assign cnt_min_x = $signed({{(RelW-CounterBits+1){1'b1}}, {(CounterBits-1){1'b0}}});
  assign reload = (reload_full < cnt_min_x) ? cnt_min_x[CounterBits-1:0]
                                            : reload_full[CounterBits-1:0];

  assign advance = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && out_valid_q && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      key_bits_q <= key_bits_i;
    end
  end

  for (genvar b = 0; b < NumButtons; b++) begin : g_btn
    kphw_button #(
      .CounterBits(CounterBits)
    ) u_button (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .adv_i    (advance),
      .closed_i (key_bits_q[BtnContact[b]]),
      .cfg_i    (cfg_q),
      .reload_i (reload),
      .event_o  (key_ev[b])
    );
  end

  kphw_wheel #(
    .CounterBits(CounterBits)
  ) u_wheel (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (advance),
    .phase_i (key_bits_q[WheelLo+2:WheelLo]),
    .event_o (wheel_ev)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      key_ev_q <= key_ev;
      wheel_ev_q <= wheel_ev;
    end
  end

  assign out_valid_o = out_valid_q;
  assign key0_event_o = key_ev_q[0];
  assign key1_event_o = key_ev_q[1];
  assign key2_event_o = key_ev_q[2];
  assign key6_event_o = key_ev_q[3];
  assign key7_event_o = key_ev_q[4];
  assign key8_event_o = key_ev_q[5];
  assign wheel_event_o = wheel_ev_q;

  `include "keypad_press_hold_wheel_decoder_assert.svh"

  `KPHW_ASSERT_IMP(a_stall_only_full, in_stall_o, s1_valid_q && out_valid_q)
  `KPHW_ASSERT_NXT(a_advance_fills_out, advance, out_valid_q)
  `KPHW_ASSERT_NXT(a_s1_held_until_adv, s1_valid_q && !advance, s1_valid_q)

endmodule
